[hw/rtl/mpa_pkg.sv]
// shared types and constants for the mirror point across axis unit
// register map codes, field widths, reset values and the axis bundle
// no dependencies
package mpa_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_W   = 14;  // widest config register
  localparam int DIM_W   = 13;  // image width and height
  localparam int DELTA_W = 15;  // end minus start of the axis
  localparam int LEN_W   = 2 * DELTA_W;  // squared axis length
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_AXIS_START_X = 3'd0,
    CFG_AXIS_START_Y = 3'd1,
    CFG_AXIS_END_X   = 3'd2,
    CFG_AXIS_END_Y   = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  localparam logic signed [CFG_W-1:0] AXIS_START_X_RST = 14'sd0;
  localparam logic signed [CFG_W-1:0] AXIS_START_Y_RST = 14'sd0;
  localparam logic signed [CFG_W-1:0] AXIS_END_X_RST   = 14'sd0;
  localparam logic signed [CFG_W-1:0] AXIS_END_Y_RST   = 14'sd4095;
  localparam logic [DIM_W-1:0]        IMAGE_WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0]        IMAGE_HEIGHT_RST = 13'd4096;

  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;

  // axis description handed from the config block to the datapath
  typedef struct packed {
    logic signed [CFG_W-1:0]   ax;
    logic signed [CFG_W-1:0]   ay;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [LEN_W-1:0]          len;
    logic                      vertical;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
  } axis_t;

endpackage

[hw/rtl/mpa_axis_regs.sv]
// configuration registers and derived axis terms (delta, squared length)
// depends on mpa_pkg
module mpa_axis_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mpa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_W-1:0]  cfg_data,
  output mpa_pkg::axis_t             axis
);

  logic signed [mpa_pkg::CFG_W-1:0]     ax;
  logic signed [mpa_pkg::CFG_W-1:0]     ay;
  logic signed [mpa_pkg::CFG_W-1:0]     bx;
  logic signed [mpa_pkg::CFG_W-1:0]     by;
  logic [mpa_pkg::DIM_W-1:0]            width;
  logic [mpa_pkg::DIM_W-1:0]            height;
  logic signed [mpa_pkg::DELTA_W-1:0]   dx;
  logic signed [mpa_pkg::DELTA_W-1:0]   dy;
  logic                                 vertical;
  logic signed [mpa_pkg::LEN_W-1:0]     dxsq;
  logic signed [mpa_pkg::LEN_W-1:0]     dysq;
  logic [mpa_pkg::LEN_W-1:0]            len;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax     <= mpa_pkg::AXIS_START_X_RST;
      ay     <= mpa_pkg::AXIS_START_Y_RST;
      bx     <= mpa_pkg::AXIS_END_X_RST;
      by     <= mpa_pkg::AXIS_END_Y_RST;
      width  <= mpa_pkg::IMAGE_WIDTH_RST;
      height <= mpa_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (mpa_pkg::cfg_reg_t'(cfg_index))
        mpa_pkg::CFG_AXIS_START_X: ax     <= $signed(cfg_data);
        mpa_pkg::CFG_AXIS_START_Y: ay     <= $signed(cfg_data);
        mpa_pkg::CFG_AXIS_END_X:   bx     <= $signed(cfg_data);
        mpa_pkg::CFG_AXIS_END_Y:   by     <= $signed(cfg_data);
        mpa_pkg::CFG_IMAGE_WIDTH:  width  <= cfg_data[mpa_pkg::DIM_W-1:0];
        mpa_pkg::CFG_IMAGE_HEIGHT: height <= cfg_data[mpa_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // derived terms are registered in turn: delta and vertical flag, then squares, then squared length
  always_ff @(posedge clk) begin
    dx       <= mpa_pkg::DELTA_W'(bx) - mpa_pkg::DELTA_W'(ax);
    dy       <= mpa_pkg::DELTA_W'(by) - mpa_pkg::DELTA_W'(ay);
    vertical <= (bx == ax);
    dxsq     <= dx * dx;
    dysq     <= dy * dy;
    len      <= $unsigned(dxsq + dysq);
  end

  assign axis.ax       = ax;
  assign axis.ay       = ay;
  assign axis.dx       = dx;
  assign axis.dy       = dy;
  assign axis.len      = len;
  assign axis.vertical = vertical;
  assign axis.width    = width;
  assign axis.height   = height;

endmodule

[hw/rtl/mpa_div_stage.sv]
// one restoring divider stage: resolves a single quotient bit per cycle while en is high
// depends on mpa_pkg
module mpa_div_stage #(
  parameter int RW    = 46,
  parameter int QB    = 16,
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [RW-1:0]              rem_in,
  input  logic [QB-1:0]              q_in,
  input  logic [mpa_pkg::LEN_W-1:0]  divisor,
  output logic [RW-1:0]              rem_out,
  output logic [QB-1:0]              q_out
);

  localparam int CW = (RW > mpa_pkg::LEN_W + SHIFT) ? RW : mpa_pkg::LEN_W + SHIFT;

  logic [CW-1:0] rem_w;
  logic [CW-1:0] sh;
  logic [CW-1:0] diff;
  logic          ge;

  assign rem_w = CW'(rem_in);
  assign sh    = CW'(divisor) << SHIFT;
  assign ge    = (rem_w >= sh);
  assign diff  = rem_w - sh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? RW'(diff) : rem_in;
      q_out   <= {q_in[QB-2:0], ge};
    end
  end

endmodule

[hw/rtl/mirror_point_across_axis_unit.sv]
// the result passes through registered stages in order: offsets, projection product, t,
//   t*d, sign and magnitude, the divider chain, F1, F2 and the output register
// throughput: one item per cycle while out_ready does not stall; the divide by the squared axis length is a chain
//   of restoring stages, one quotient bit each, so its length sets the latency
// stalls propagate stage by stage, empty stages keep filling while a result waits
// reset clears all valid bits and loads the register defaults; axis terms derived
//   from the registers follow through the delta, square and squared length registers
// depends on mpa_pkg, mpa_axis_regs, mpa_div_stage
module mirror_point_across_axis_unit #(
  parameter int COORD_BITS = mpa_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mpa_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mpa_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mpa_pkg::OUT_W-1:0]  mirror_x,
  output logic signed [mpa_pkg::OUT_W-1:0]  mirror_y,
  output logic                              inside_image,
  output logic                              on_axis
);

  localparam int MAXC = (COORD_BITS > 13) ? COORD_BITS : 13;
  localparam int DW   = MAXC + 2;                         // pixel minus axis start
  localparam int KW   = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;  // 2*start - pixel
  localparam int MW   = DW + mpa_pkg::DELTA_W;
  localparam int TW   = MW + 1;                           // projection t
  localparam int PW   = TW + mpa_pkg::DELTA_W;
  localparam int RW   = PW;                               // |2*t*d|
  localparam int QB   = MAXC + 3;                         // quotient bits
  localparam int FW   = QB + 2;
  localparam int SW   = ((KW > FW) ? KW : FW) + 1;

  localparam int ST_DIV = 6;
  localparam int ST_F1  = ST_DIV + QB;
  localparam int ST_F2  = ST_F1 + 1;
  localparam int ST_OUT = ST_F2 + 1;
  localparam int NS     = ST_OUT + 1;

  mpa_pkg::axis_t axis;

  mpa_axis_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis      (axis)
  );

  // ---- valid bits and stage enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign in_ready  = en[0] && !rst;
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---- side payload carried along
  logic [COORD_BITS-1:0] px_p [0:ST_F2];
  logic [COORD_BITS-1:0] py_p [0:ST_F2];
  logic signed [KW-1:0]  kx_p [1:ST_F2];
  logic signed [KW-1:0]  ky_p [1:ST_F2];
  logic                  neg_x_p [5:ST_F1-1];
  logic                  neg_y_p [5:ST_F1-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_p[0] <= pixel_x;
      py_p[0] <= pixel_y;
    end
  end

  for (genvar i = 1; i <= ST_F2; i++) begin : g_pix
    always_ff @(posedge clk) begin
      if (en[i]) begin
        px_p[i] <= px_p[i-1];
        py_p[i] <= py_p[i-1];
      end
    end
  end

  for (genvar i = 2; i <= ST_F2; i++) begin : g_k
    always_ff @(posedge clk) begin
      if (en[i]) begin
        kx_p[i] <= kx_p[i-1];
        ky_p[i] <= ky_p[i-1];
      end
    end
  end

  for (genvar i = ST_DIV; i <= ST_F1 - 1; i++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en[i]) begin
        neg_x_p[i] <= neg_x_p[i-1];
        neg_y_p[i] <= neg_y_p[i-1];
      end
    end
  end

  // ---- stage 1: offsets from the axis start and the point mirrored through it
  logic signed [DW-1:0] dfx;
  logic signed [DW-1:0] dfy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dfx     <= DW'($signed({1'b0, px_p[0]})) - DW'(axis.ax);
      dfy     <= DW'($signed({1'b0, py_p[0]})) - DW'(axis.ay);
      kx_p[1] <= (KW'(axis.ax) <<< 1) - KW'($signed({1'b0, px_p[0]}));
      ky_p[1] <= (KW'(axis.ay) <<< 1) - KW'($signed({1'b0, py_p[0]}));
    end
  end

  // ---- stages 2..4: projection t and t*d
  logic signed [MW-1:0] mulx;
  logic signed [MW-1:0] muly;
  logic signed [TW-1:0] t;
  logic signed [PW-1:0] rx;
  logic signed [PW-1:0] ry;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mulx <= dfx * axis.dx;
      muly <= dfy * axis.dy;
    end
    if (en[3]) begin
      t <= TW'(mulx) + TW'(muly);
    end
    if (en[4]) begin
      rx <= t * axis.dx;
      ry <= t * axis.dy;
    end
  end

  // ---- stage 5: sign and magnitude for the divider, doubling folded in
  logic [PW-1:0] abs_x;
  logic [PW-1:0] abs_y;
  logic [RW-1:0] mag_x;
  logic [RW-1:0] mag_y;

  assign abs_x = rx[PW-1] ? $unsigned(-rx) : $unsigned(rx);
  assign abs_y = ry[PW-1] ? $unsigned(-ry) : $unsigned(ry);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mag_x      <= {abs_x[PW-2:0], 1'b0};
      mag_y      <= {abs_y[PW-2:0], 1'b0};
      neg_x_p[5] <= rx[PW-1];
      neg_y_p[5] <= ry[PW-1];
    end
  end

  // ---- divider chain, msb of the quotient first
  logic [RW-1:0] rem_x [QB];
  logic [RW-1:0] rem_y [QB];
  logic [QB-1:0] q_x   [QB];
  logic [QB-1:0] q_y   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    if (j == 0) begin : g_first
      mpa_div_stage #(.RW(RW), .QB(QB), .SHIFT(QB - 1 - j)) u_div_x (
        .clk (clk), .en (en[ST_DIV+j]), .rem_in (mag_x), .q_in ('0),
        .divisor (axis.len), .rem_out (rem_x[j]), .q_out (q_x[j])
      );
      mpa_div_stage #(.RW(RW), .QB(QB), .SHIFT(QB - 1 - j)) u_div_y (
        .clk (clk), .en (en[ST_DIV+j]), .rem_in (mag_y), .q_in ('0),
        .divisor (axis.len), .rem_out (rem_y[j]), .q_out (q_y[j])
      );
    end else begin : g_next
      mpa_div_stage #(.RW(RW), .QB(QB), .SHIFT(QB - 1 - j)) u_div_x (
        .clk (clk), .en (en[ST_DIV+j]), .rem_in (rem_x[j-1]), .q_in (q_x[j-1]),
        .divisor (axis.len), .rem_out (rem_x[j]), .q_out (q_x[j])
      );
      mpa_div_stage #(.RW(RW), .QB(QB), .SHIFT(QB - 1 - j)) u_div_y (
        .clk (clk), .en (en[ST_DIV+j]), .rem_in (rem_y[j-1]), .q_in (q_y[j-1]),
        .divisor (axis.len), .rem_out (rem_y[j]), .q_out (q_y[j])
      );
    end
  end

  // ---- F1: signed floor of 2*t*d / len
  logic signed [FW-1:0] qs_x;
  logic signed [FW-1:0] qs_y;
  logic                 nzr_x;
  logic                 nzr_y;
  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;
  logic                 nz_x;
  logic                 nz_y;

  assign qs_x  = $signed(FW'(q_x[QB-1]));
  assign qs_y  = $signed(FW'(q_y[QB-1]));
  assign nzr_x = |rem_x[QB-1];
  assign nzr_y = |rem_y[QB-1];

  always_ff @(posedge clk) begin
    if (en[ST_F1]) begin
      fx   <= neg_x_p[ST_F1-1] ? -qs_x - FW'(nzr_x) : qs_x;
      fy   <= neg_y_p[ST_F1-1] ? -qs_y - FW'(nzr_y) : qs_y;
      nz_x <= nzr_x;
      nz_y <= nzr_y;
    end
  end

  // ---- F2: floor of the mirrored coordinate, 2*start - pixel plus the quotient
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic                 nz_x2;
  logic                 nz_y2;

  always_ff @(posedge clk) begin
    if (en[ST_F2]) begin
      sx    <= SW'(kx_p[ST_F1]) + SW'(fx);
      sy    <= SW'(ky_p[ST_F1]) + SW'(fy);
      nz_x2 <= nz_x;
      nz_y2 <= nz_y;
    end
  end

  // ---- output stage: floor to truncation, vertical axis, flags, clamp
  function automatic logic signed [mpa_pkg::OUT_W-1:0] sat_out(
    input logic signed [SW-1:0] val
  );
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    lo = SW'(mpa_pkg::OUT_MIN);
    hi = SW'(mpa_pkg::OUT_MAX);
    if (val < lo) begin
      return mpa_pkg::OUT_MIN;
    end else if (val > hi) begin
      return mpa_pkg::OUT_MAX;
    end
    return val[mpa_pkg::OUT_W-1:0];
  endfunction

  logic signed [SW-1:0] px_s;
  logic signed [SW-1:0] py_s;
  logic signed [SW-1:0] mx_full;
  logic signed [SW-1:0] my_full;
  logic signed [SW-1:0] w_s;
  logic signed [SW-1:0] h_s;

  assign px_s = SW'($signed({1'b0, px_p[ST_F2]}));
  assign py_s = SW'($signed({1'b0, py_p[ST_F2]}));
  assign w_s  = SW'($signed({1'b0, axis.width}));
  assign h_s  = SW'($signed({1'b0, axis.height}));

  // a negative inexact result rounds up by one toward zero
  assign mx_full = axis.vertical ? SW'(kx_p[ST_F2]) : sx + SW'(sx[SW-1] & nz_x2);
  assign my_full = axis.vertical ? py_s : sy + SW'(sy[SW-1] & nz_y2);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      mirror_x     <= sat_out(mx_full);
      mirror_y     <= sat_out(my_full);
      inside_image <= !mx_full[SW-1] && (mx_full < w_s) &&
                      !my_full[SW-1] && (my_full < h_s);
      on_axis      <= (mx_full == px_s) && (my_full == py_s);
    end
  end

  // ---- checks
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
      |=> $countones(v) == $past($countones(v)) + 1)
    else $error("pipeline occupancy did not grow on an accepted item");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && out_valid && out_ready)
      |=> $countones(v) + 1 == $past($countones(v)))
    else $error("pipeline occupancy did not shrink on a delivered item");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    (v[ST_F1-1] && !axis.vertical) |-> rem_x[QB-1] < RW'(axis.len) &&
      rem_y[QB-1] < RW'(axis.len))
    else $error("divider remainder not below the squared axis length");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && inside_image) |-> !mirror_x[mpa_pkg::OUT_W-1] &&
      !mirror_y[mpa_pkg::OUT_W-1])
    else $error("mirror flagged inside the image with a negative coordinate");

endmodule
